@@ sv/kap_pkg.sv @@
// Package for the keyed ARX permutation: payload structs, register indexes,
// rotation amounts and the round function. Depends on nothing else.
package kap_pkg;

  localparam int WORD_W         = 32;
  localparam int ROUNDS_DEFAULT = 8;
  localparam int CFG_INDEX_W    = 2;

  // Rotation amounts of one round.
  localparam int ROT_B1 = 5;
  localparam int ROT_A  = 16;
  localparam int ROT_D1 = 8;
  localparam int ROT_D2 = 13;
  localparam int ROT_B2 = 7;
  localparam int ROT_C  = 16;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Register indexes of the key words.
  localparam cfg_index_t KEY_IDX0 = 2'd0;
  localparam cfg_index_t KEY_IDX1 = 2'd1;
  localparam cfg_index_t KEY_IDX2 = 2'd2;
  localparam cfg_index_t KEY_IDX3 = 2'd3;

  typedef struct packed {
    word_t in_word0;
    word_t in_word1;
    word_t in_word2;
    word_t in_word3;
  } in_t;

  typedef struct packed {
    word_t out_word0;
    word_t out_word1;
    word_t out_word2;
    word_t out_word3;
    word_t fold_high;
    word_t fold_low;
  } out_t;

  // Four working words of the permutation.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } state_t;

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  // One round; the two halves run side by side, so the deepest path is two adds.
  function automatic state_t round_f(input state_t s);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    state_t r;
    a = s.a;
    b = s.b;
    c = s.c;
    d = s.d;
    a = a + b; b = rotl(b, ROT_B1); b = b ^ a; a = rotl(a, ROT_A);
    c = c + d; d = rotl(d, ROT_D1); d = d ^ c;
    a = a + d; d = rotl(d, ROT_D2); d = d ^ a;
    c = c + b; b = rotl(b, ROT_B2); b = b ^ c; c = rotl(c, ROT_C);
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    round_f = r;
  endfunction

endpackage

@@ sv/keyed_arx_permutation_128.sv @@
// Top level of the keyed 128-bit ARX permutation: key registers, a chain of
// round cells and the output cell. Depends on kap_pkg, kap_round_cell, kap_out_stage.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data  (kap_pkg::in_t)
//   out      output     out_valid / out_ready   out_data (kap_pkg::out_t)
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// A block accepted at the input passes through the ROUNDS round cells and then
// the output cell; one block is taken every cycle while the output side does
// not stall. Each round cell is one round deep (two dependent 32-bit adds).
// Reset (rst, synchronous) empties every cell and clears the key to zero.
// A stall at the output fills empty cells first; in_ready falls only once
// all ROUNDS + 1 cells hold a block.
module keyed_arx_permutation_128 #(
  parameter int ROUNDS = kap_pkg::ROUNDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kap_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kap_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  kap_pkg::cfg_index_t cfg_index,
  input  kap_pkg::word_t      cfg_data
);

  // Key registers: the user must change them only with no transaction in flight,
  // so the same key serves the opening and closing XOR; the block does not check it.
  kap_pkg::state_t key;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kap_pkg::KEY_IDX0: key.a <= cfg_data;
        kap_pkg::KEY_IDX1: key.b <= cfg_data;
        kap_pkg::KEY_IDX2: key.c <= cfg_data;
        kap_pkg::KEY_IDX3: key.d <= cfg_data;
        default: ;
      endcase
    end
  end

  // Link signals of the chain: link 0 is the input, link ROUNDS feeds the
  // output cell.
  logic            link_valid [ROUNDS+1];
  logic            link_ready [ROUNDS+1];
  kap_pkg::state_t link_data  [ROUNDS+1];

  // The opening key XOR sits in front of the first cell.
  assign link_valid[0]  = in_valid;
  assign in_ready       = link_ready[0];
  assign link_data[0].a = in_data.in_word0 ^ key.a;
  assign link_data[0].b = in_data.in_word1 ^ key.b;
  assign link_data[0].c = in_data.in_word2 ^ key.c;
  assign link_data[0].d = in_data.in_word3 ^ key.d;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    kap_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid_up   (link_valid[i]),
      .ready_up   (link_ready[i]),
      .data_up    (link_data[i]),
      .valid_down (link_valid[i+1]),
      .ready_down (link_ready[i+1]),
      .data_down  (link_data[i+1])
    );
  end

  kap_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_up  (link_valid[ROUNDS]),
    .ready_up  (link_ready[ROUNDS]),
    .data_up   (link_data[ROUNDS]),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Count of transactions in flight, kept for the checks below.
  localparam int DEPTH   = ROUNDS + 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [COUNT_W-1:0] in_flight;
  logic [COUNT_W-1:0] in_flight_next;
  logic [ROUNDS-1:0]  cell_valid;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_valid
    assign cell_valid[i] = link_valid[i+1];
  end

  always_comb begin
    in_flight_next = in_flight;
    if (in_valid && in_ready) begin
      in_flight_next = in_flight_next + COUNT_W'(1);
    end
    if (out_valid && out_ready) begin
      in_flight_next = in_flight_next - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight_next;
    end
  end

  // The chain never holds more blocks than it has cells.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= COUNT_W'(DEPTH))
    else $error("more transactions in flight than cells");

  // The input is refused only when every cell is full and the output stalls.
  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&cell_valid) && out_valid && !out_ready
      && in_flight == COUNT_W'(DEPTH))
    else $error("input refused while a cell is empty");

  // An empty count means no cell holds a block.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> !(|cell_valid) && !out_valid)
    else $error("cell valid with no transaction in flight");

  // A block accepted into an empty chain enters the first cell.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_flight == '0 && in_valid && in_ready) |=> link_valid[1])
    else $error("accepted block did not enter the first cell");

endmodule

@@ sv/kap_round_cell.sv @@
// One round cell of the permutation chain: holds one block and its valid bit.
// Depends on kap_pkg for the state type and the round function.
module kap_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_up,
  output logic            ready_up,
  input  kap_pkg::state_t data_up,
  output logic            valid_down,
  input  logic            ready_down,
  output kap_pkg::state_t data_down
);

  logic            valid;
  kap_pkg::state_t data;

  // The cell takes a new block when it is empty or its block moves on.
  assign ready_up   = !valid || ready_down;
  assign valid_down = valid;
  assign data_down  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= kap_pkg::round_f(data_up);
    end
  end

endmodule

@@ sv/kap_out_stage.sv @@
// Output cell: applies the closing key XOR, forms the folded words and holds
// the result until it is taken. Depends on kap_pkg for the payload types.
module kap_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_up,
  output logic            ready_up,
  input  kap_pkg::state_t data_up,
  input  kap_pkg::state_t key,
  output logic            out_valid,
  input  logic            out_ready,
  output kap_pkg::out_t   out_data
);

  logic          valid;
  kap_pkg::out_t data;
  kap_pkg::out_t data_next;

  assign ready_up  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.out_word0 = data_up.a ^ key.a;
    data_next.out_word1 = data_up.b ^ key.b;
    data_next.out_word2 = data_up.c ^ key.c;
    data_next.out_word3 = data_up.d ^ key.d;
    data_next.fold_high = data_next.out_word0 ^ data_next.out_word1;
    data_next.fold_low  = data_next.out_word2 ^ data_next.out_word3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= data_next;
    end
  end

endmodule

@@ tb/tb_keyed_arx_permutation_128.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for keyed_arx_permutation_128: random and directed blocks
// under several keys, with bursty input and a stalling output. Depends on kap_pkg.
module tb_keyed_arx_permutation_128;

  localparam int ROUNDS       = kap_pkg::ROUNDS_DEFAULT;
  localparam int CLK_HALF_NS  = 5;
  localparam int RESET_CYCLES = 12;
  // Generous ceiling on the whole run, in nanoseconds.
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 170;
  localparam int PAUSE_ITEMS      = 40;

  localparam kap_pkg::word_t ALL_ONES = 32'hFFFF_FFFF;
  localparam kap_pkg::word_t ALL_ZERO = 32'h0000_0000;

  localparam kap_pkg::cfg_index_t KEY_INDEXES [4] = '{
    kap_pkg::KEY_IDX0, kap_pkg::KEY_IDX1, kap_pkg::KEY_IDX2, kap_pkg::KEY_IDX3
  };

  // Output stall patterns; each one lasts for a random stretch of cycles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  // Every input of the block holds a known value from time zero.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  kap_pkg::in_t        in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kap_pkg::out_t       out_data;
  logic                cfg_we    = 1'b0;
  kap_pkg::cfg_index_t cfg_index = kap_pkg::KEY_IDX0;
  kap_pkg::word_t      cfg_data  = '0;

  // Our own copy of the key registers, mirrored on every write.
  kap_pkg::word_t key_model [4] = '{ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO};

  // Permuted blocks still owed by the block, oldest first.
  kap_pkg::out_t expected_blocks [$];

  int unsigned blocks_sent   = 0;
  int unsigned blocks_seen   = 0;
  int unsigned key_settings  = 1;
  int unsigned error_count   = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  bit          gaps_enabled = 1'b1;
  int unsigned burst_left   = 0;

  keyed_arx_permutation_128 #(
    .ROUNDS(ROUNDS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic kap_pkg::word_t rol32(kap_pkg::word_t x, int unsigned n);
    return (x << n) | (x >> (kap_pkg::WORD_W - n));
  endfunction

  // Whitens the block with the key, runs the ARX rounds and whitens again.
  // Both halves of a round are written out in the order the scheme defines;
  // all sums wrap at 32 bits because the words are 32 bits wide.
  function automatic kap_pkg::out_t permute_block(kap_pkg::in_t blk);
    kap_pkg::word_t a;
    kap_pkg::word_t b;
    kap_pkg::word_t c;
    kap_pkg::word_t d;
    kap_pkg::out_t  res;
    a = blk.in_word0 ^ key_model[kap_pkg::KEY_IDX0];
    b = blk.in_word1 ^ key_model[kap_pkg::KEY_IDX1];
    c = blk.in_word2 ^ key_model[kap_pkg::KEY_IDX2];
    d = blk.in_word3 ^ key_model[kap_pkg::KEY_IDX3];
    for (int r = 0; r < ROUNDS; r++) begin
      a = a + b; b = rol32(b, 5);  b = b ^ a; a = rol32(a, 16);
      c = c + d; d = rol32(d, 8);  d = d ^ c;
      a = a + d; d = rol32(d, 13); d = d ^ a;
      c = c + b; b = rol32(b, 7);  b = b ^ c; c = rol32(c, 16);
    end
    res.out_word0 = a ^ key_model[kap_pkg::KEY_IDX0];
    res.out_word1 = b ^ key_model[kap_pkg::KEY_IDX1];
    res.out_word2 = c ^ key_model[kap_pkg::KEY_IDX2];
    res.out_word3 = d ^ key_model[kap_pkg::KEY_IDX3];
    // The folded words XOR out_word0 with out_word1 and out_word2 with out_word3.
    res.fold_high = res.out_word0 ^ res.out_word1;
    res.fold_low  = res.out_word2 ^ res.out_word3;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is matched against the oldest
  // expected block, one field at a time.
  // ---------------------------------------------------------------------------

  task automatic check_word(string field, kap_pkg::word_t exp_w, kap_pkg::word_t act_w);
    if (act_w !== exp_w) begin
      error_count++;
      $display("%0t: mismatch on %s, expected %08h, actual %08h",
               $time, field, exp_w, act_w);
    end
  endtask

  kap_pkg::out_t owed_block;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_data);
      end else begin
        owed_block = expected_blocks.pop_front();
        blocks_seen++;
        check_word("out_word0", owed_block.out_word0, out_data.out_word0);
        check_word("out_word1", owed_block.out_word1, out_data.out_word1);
        check_word("out_word2", owed_block.out_word2, out_data.out_word2);
        check_word("out_word3", owed_block.out_word3, out_data.out_word3);
        check_word("fold_high", owed_block.fold_high, out_data.fold_high);
        check_word("fold_low",  owed_block.fold_low,  out_data.fold_low);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall generator. It switches between patterns so that a stall can
  // land while any number of cells in the round chain are full.
  // ---------------------------------------------------------------------------

  rx_mode_t    rx_mode    = RX_ALWAYS;
  int unsigned rx_left    = 0;
  int unsigned rx_phase   = 0;
  int unsigned rx_period  = 3;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 11);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= ((rx_phase % rx_period) != 0);
      default:     out_ready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Presents one block and holds it until the input transaction completes,
  // then records the permuted block the output owes us. Valid is not lowered
  // here, so back-to-back blocks keep it high without a glitch.
  task automatic send_block(kap_pkg::in_t blk);
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (!in_ready);
    expected_blocks.push_back(permute_block(blk));
    blocks_sent++;
    @(negedge clk);
  endtask

  // Ends the current burst with a gap when its length is used up.
  task automatic pace_sender();
    int unsigned gap;
    if (!gaps_enabled) begin
      return;
    end
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_paced(kap_pkg::in_t blk);
    send_block(blk);
    pace_sender();
  endtask

  // Lets every owed block come out and then waits on, so that the block is
  // idle before a key change or the end of a phase.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes the key words selected by mask, one per cycle, then drops the
  // write enable once. Only called while nothing is in flight.
  task automatic load_key(kap_pkg::word_t k [4], bit [3:0] mask);
    foreach (KEY_INDEXES[i]) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= KEY_INDEXES[i];
        cfg_data  <= k[i];
        key_model[KEY_INDEXES[i]] = k[i];
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    key_settings++;
  endtask

  function automatic kap_pkg::in_t make_block(kap_pkg::word_t w0, kap_pkg::word_t w1,
                                              kap_pkg::word_t w2, kap_pkg::word_t w3);
    kap_pkg::in_t blk;
    blk.in_word0 = w0;
    blk.in_word1 = w1;
    blk.in_word2 = w2;
    blk.in_word3 = w3;
    return blk;
  endfunction

  // A word that is often an edge value and otherwise fully random.
  function automatic kap_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return ALL_ZERO;
      1:       return ALL_ONES;
      2:       return kap_pkg::word_t'(1) << $urandom_range(0, 31);
      3:       return ~(kap_pkg::word_t'(1) << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Mostly fully random blocks, some in the 64-bit form with the upper words
  // zero, and some built from edge-value words.
  function automatic kap_pkg::in_t random_block();
    case ($urandom_range(0, 19))
      0, 1, 2:
        return make_block($urandom(), $urandom(), ALL_ZERO, ALL_ZERO);
      3, 4, 5:
        return make_block(pick_word(), pick_word(), pick_word(), pick_word());
      default:
        return make_block($urandom(), $urandom(), $urandom(), $urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The key is zero out of reset, so these blocks go through the bare
  // permutation. The 64-bit form is the full form with the upper words zero.
  task automatic test_reset_key();
    send_paced(make_block(ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO));
    send_paced(make_block(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_paced(make_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_paced(make_block(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_paced(make_block(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    send_paced(make_block(ALL_ONES, ALL_ONES, ALL_ZERO, ALL_ZERO));
    send_paced(make_block($urandom(), $urandom(), ALL_ZERO, ALL_ZERO));
    send_paced(make_block(ALL_ZERO, ALL_ZERO, ALL_ONES, ALL_ONES));
    wait_for_drain();
  endtask

  // Extreme keys. A block equal to the key whitens to an all-zero state,
  // and a wrapping sum is forced by the all-ones words.
  task automatic test_key_extremes();
    kap_pkg::word_t k [4];
    k = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};
    load_key(k, 4'b1111);
    send_paced(make_block(ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO));
    send_paced(make_block(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_paced(make_block($urandom(), $urandom(), ALL_ZERO, ALL_ZERO));
    send_paced(make_block(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001));
    wait_for_drain();
    k = '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210};
    load_key(k, 4'b1111);
    send_paced(make_block(k[0], k[1], k[2], k[3]));
    send_paced(make_block(~k[0], ~k[1], ~k[2], ~k[3]));
    send_paced(make_block(ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO));
    // Only the odd words change here; the even words keep their old value.
    k = '{ALL_ZERO, ALL_ONES, ALL_ZERO, ALL_ONES};
    wait_for_drain();
    load_key(k, 4'b1010);
    send_paced(make_block(ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO));
    send_paced(make_block(32'hDEAD_BEEF, 32'hCAFE_F00D, ALL_ZERO, ALL_ZERO));
    wait_for_drain();
  endtask

  // Long random streams under a new key per phase. The first and last phase
  // use the all-zero and all-ones keys; one phase runs with no input gaps.
  task automatic test_random_traffic();
    kap_pkg::word_t k [4];
    bit [3:0]       mask;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mask = 4'b1111;
      if (p == 0) begin
        k = '{ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO};
      end else if (p == RANDOM_PHASES - 1) begin
        k = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};
      end else begin
        k = '{$urandom(), $urandom(), $urandom(), $urandom()};
        if (p == 3) begin
          mask = 4'($urandom_range(1, 15));
        end
      end
      load_key(k, mask);
      gaps_enabled = (p != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_paced(random_block());
      end
      wait_for_drain();
    end
    gaps_enabled = 1'b1;
  endtask

  // The sender stops until every owed block has come out, waits a while with
  // the chain empty, and then resumes at full rate.
  task automatic test_pause_and_resume();
    kap_pkg::word_t k [4];
    k = '{$urandom(), $urandom(), $urandom(), $urandom()};
    load_key(k, 4'b1111);
    gaps_enabled = 1'b0;
    for (int n = 0; n < PAUSE_ITEMS / 2; n++) begin
      send_paced(random_block());
    end
    wait_for_drain();
    repeat ($urandom_range(5, 30)) @(negedge clk);
    for (int n = 0; n < PAUSE_ITEMS / 2; n++) begin
      send_paced(random_block());
    end
    gaps_enabled = 1'b1;
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_key();
    test_key_extremes();
    test_random_traffic();
    test_pause_and_resume();

    // Nothing is owed now; give a stray result the full latency to show up.
    wait_for_drain();
    repeat (ROUNDS + 8) @(negedge clk);
    if (expected_blocks.size() != 0) begin
      error_count++;
      $display("%0t: blocks still owed at the end, expected 0, actual %0d",
               $time, expected_blocks.size());
    end

    $display("Ran %0d blocks through %0d key settings; %0d results were checked.",
             blocks_sent, key_settings, blocks_seen);
    $display("Input bursts, output stalls and a full drain pause were exercised.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard ceiling on the run in case a transaction never completes.
  initial begin
    #RUN_LIMIT_NS;
    $display("%0t: run limit reached with %0d blocks still owed",
             $time, expected_blocks.size());
    $display("FAILURE");
    $finish;
  end

endmodule
